### rtl/moving_average_crossover_detector_core_defines.svh
// assertion macros shared by the rtl
`ifndef MOVING_AVERAGE_CROSSOVER_DETECTOR_CORE_DEFINES_SVH
`define MOVING_AVERAGE_CROSSOVER_DETECTOR_CORE_DEFINES_SVH

// condition implies consequence in the same cycle
`define MACR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define MACR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/macr_pkg.sv
package macr_pkg;

  // width of a window register
  localparam int WIN_REG_W = 9;

  // window register reset values
  localparam logic [WIN_REG_W-1:0] FAST_RESET = 9'd10;
  localparam logic [WIN_REG_W-1:0] SLOW_RESET = 9'd30;

  // register indexes on the configuration port
  typedef logic [0:0] reg_idx_t;
  localparam reg_idx_t REG_FAST_WINDOW = 1'b0;
  localparam reg_idx_t REG_SLOW_WINDOW = 1'b1;

  // cross signal codes
  typedef logic signed [1:0] sig_t;
  localparam sig_t SIG_NONE = 2'sb00;
  localparam sig_t SIG_BUY  = 2'sb01;
  localparam sig_t SIG_SELL = 2'sb11;

  // control states
  typedef enum logic [0:0] {
    ST_RUN,
    ST_SWEEP
  } state_t;

endpackage

### rtl/macr_ram.sv
module macr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 257
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/moving_average_crossover_detector_core.sv
// Moving average crossover detector.
// Input channel (in_valid/in_stall) takes one closing price per request, with
// in_series_start marking the first sample of a new series. Every request gives
// exactly one result on the output channel (out_valid/out_stall): +1 when the
// fast average crosses above the slow one, -1 for a cross below, 0 otherwise.
// Results stay 0 until more samples than the larger window have arrived.
// Windows are set through the cfg port (index 0 fast, 1 slow), clamped to
// 1..MAX_WINDOW. Throughput is one request per cycle while in_stall is low; a
// result is presented after the stages history read, running sums, multiply
// and compare. The two running sums are registered loops, each fed by a
// history RAM read of the sample leaving its window.
// After each configuration write the sums are rebuilt from the history in a
// sweep pass, during which in_stall is held high and cfg_ready low.
// Synchronous reset clears the sample count and sums, windows reset to 10 and 30.
// While a presented result is stalled (out_valid and out_stall high) the whole
// pipeline holds and in_stall is raised, so a presented result is never lost
// or changed.
`include "moving_average_crossover_detector_core_defines.svh"

module moving_average_crossover_detector_core #(
  parameter int MAX_WINDOW = 256,
  parameter int PRICE_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [PRICE_BITS-1:0]             in_close_price,
  input  logic                              in_series_start,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [1:0]                 out_cross_signal,
  // configuration channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  macr_pkg::reg_idx_t                cfg_index,
  input  logic [macr_pkg::WIN_REG_W-1:0]    cfg_data
);

  localparam int DEPTH  = MAX_WINDOW + 1;
  localparam int AW     = $clog2(DEPTH);
  localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CW     = (WIN_W > macr_pkg::WIN_REG_W) ? WIN_W : macr_pkg::WIN_REG_W;
  localparam int SUM_W  = PRICE_BITS + WIN_W;
  localparam int PROD_W = SUM_W + WIN_W;

  // clamp a window register to 1..MAX_WINDOW
  function automatic logic [WIN_W-1:0] eff_win(input logic [macr_pkg::WIN_REG_W-1:0] w);
    logic [CW-1:0] wx;
    wx = CW'(w);
    if (wx == '0) return WIN_W'(1);
    else if (wx > CW'(MAX_WINDOW)) return WIN_W'(MAX_WINDOW);
    else return WIN_W'(wx);
  endfunction

  // configuration and control state
  logic [macr_pkg::WIN_REG_W-1:0] fast_win_r, slow_win_r;
  macr_pkg::state_t               state_r, state_nxt;
  logic [CNT_W-1:0]               cnt_r, cnt_nxt;
  logic [AW-1:0]                  wp_r, wp_nxt;
  logic [WIN_W-1:0]               fw, sw, maxw;

  // sweep state
  logic [WIN_W-1:0] swp_age_r, swp_age_d_r;
  logic [AW-1:0]    swp_slot_r;
  logic             swp_dv_r, swp_issue;

  // pipeline
  logic                  adv, in_acc, cfg_acc;
  logic                  s1_v_r, s1_start_r, s1_subf_r, s1_subs_r, s1_warm_r;
  logic [PRICE_BITS-1:0] s1_price_r;
  logic                  s2_v_r, s2_warm_r;
  logic [SUM_W-1:0]      fsum_r, ssum_r, fbef_r, sbef_r, fsum_nxt, ssum_nxt;
  logic                  s3_v_r, s3_warm_r;
  logic [PROD_W-1:0]     pf_now_r, ps_now_r, pf_bef_r, ps_bef_r;
  logic                  out_valid_r;
  macr_pkg::sig_t        out_sig_r, sig_nxt;

  // history ram ports
  logic [AW-1:0]         rd_f, rd_s, raddr_a;
  logic [AW:0]           wpx, fwx, swx;
  logic [PRICE_BITS-1:0] ram_a_rdata, ram_b_rdata;
  logic                  re_a;

  assign fw   = eff_win(fast_win_r);
  assign sw   = eff_win(slow_win_r);
  assign maxw = (fw > sw) ? fw : sw;

  // handshakes
  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv || (state_r != macr_pkg::ST_RUN);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = (state_r == macr_pkg::ST_RUN);
  assign cfg_acc   = cfg_valid && cfg_ready;

  // window registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_win_r <= macr_pkg::FAST_RESET;
      slow_win_r <= macr_pkg::SLOW_RESET;
    end else if (cfg_acc) begin
      unique case (cfg_index)
        macr_pkg::REG_FAST_WINDOW: fast_win_r <= cfg_data;
        macr_pkg::REG_SLOW_WINDOW: slow_win_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ring pointer and saturating sample count
  always_comb begin
    logic [CNT_W-1:0] base;
    base    = in_series_start ? '0 : cnt_r;
    cnt_nxt = (base == CNT_W'(DEPTH)) ? base : base + 1'b1;
    wp_nxt  = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= '0;
    end else if (in_acc) begin
      cnt_r <= cnt_nxt;
      wp_r  <= wp_nxt;
    end
  end

  // slots of the samples leaving each window
  always_comb begin
    wpx  = {1'b0, wp_nxt};
    fwx  = (AW+1)'(fw);
    swx  = (AW+1)'(sw);
    rd_f = (wpx >= fwx) ? AW'(wpx - fwx) : AW'(wpx + (AW+1)'(DEPTH) - fwx);
    rd_s = (wpx >= swx) ? AW'(wpx - swx) : AW'(wpx + (AW+1)'(DEPTH) - swx);
  end

  // history copies, one read port per window
  assign swp_issue = (state_r == macr_pkg::ST_SWEEP) && (swp_age_r != WIN_W'(MAX_WINDOW));
  assign raddr_a   = (state_r == macr_pkg::ST_SWEEP) ? swp_slot_r : rd_f;
  assign re_a      = in_acc || swp_issue;

  macr_ram #(.WIDTH(PRICE_BITS), .DEPTH(DEPTH)) u_hist_fast (
    .clk   (clk),
    .we    (in_acc),
    .waddr (wp_nxt),
    .wdata (in_close_price),
    .re    (re_a),
    .raddr (raddr_a),
    .rdata (ram_a_rdata)
  );

  macr_ram #(.WIDTH(PRICE_BITS), .DEPTH(DEPTH)) u_hist_slow (
    .clk   (clk),
    .we    (in_acc),
    .waddr (wp_nxt),
    .wdata (in_close_price),
    .re    (in_acc),
    .raddr (rd_s),
    .rdata (ram_b_rdata)
  );

  // stage 1: request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_price_r <= in_close_price;
      s1_start_r <= in_series_start;
      s1_subf_r  <= cnt_nxt > CNT_W'(fw);
      s1_subs_r  <= cnt_nxt > CNT_W'(sw);
      s1_warm_r  <= cnt_nxt > CNT_W'(maxw);
    end
  end

  // stage 2: running sums, rebuilt by the sweep after a window change
  always_comb begin
    fsum_nxt = fsum_r;
    ssum_nxt = ssum_r;
    if (cfg_acc) begin
      fsum_nxt = '0;
      ssum_nxt = '0;
    end else if (swp_dv_r) begin
      if ((CNT_W'(swp_age_d_r) < cnt_r) && (swp_age_d_r < fw)) begin
        fsum_nxt = fsum_r + SUM_W'(ram_a_rdata);
      end
      if ((CNT_W'(swp_age_d_r) < cnt_r) && (swp_age_d_r < sw)) begin
        ssum_nxt = ssum_r + SUM_W'(ram_a_rdata);
      end
    end else if (adv && s1_v_r) begin
      fsum_nxt = (s1_start_r ? '0 : fsum_r) + SUM_W'(s1_price_r)
                 - (s1_subf_r ? SUM_W'(ram_a_rdata) : '0);
      ssum_nxt = (s1_start_r ? '0 : ssum_r) + SUM_W'(s1_price_r)
                 - (s1_subs_r ? SUM_W'(ram_b_rdata) : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsum_r <= '0;
      ssum_r <= '0;
      fbef_r <= '0;
      sbef_r <= '0;
      s2_v_r <= 1'b0;
    end else begin
      fsum_r <= fsum_nxt;
      ssum_r <= ssum_nxt;
      if (adv) begin
        s2_v_r <= s1_v_r;
        if (s1_v_r) begin
          fbef_r <= fsum_r;
          sbef_r <= ssum_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_v_r) begin
      s2_warm_r <= s1_warm_r;
    end
  end

  // stage 3: cross products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_v_r) begin
      s3_warm_r <= s2_warm_r;
      pf_now_r  <= PROD_W'(fsum_r) * PROD_W'(sw);
      ps_now_r  <= PROD_W'(ssum_r) * PROD_W'(fw);
      pf_bef_r  <= PROD_W'(fbef_r) * PROD_W'(sw);
      ps_bef_r  <= PROD_W'(sbef_r) * PROD_W'(fw);
    end
  end

  // stage 4: compare and output register
  always_comb begin
    sig_nxt = macr_pkg::SIG_NONE;
    if (s3_warm_r) begin
      if (!(pf_bef_r > ps_bef_r) && (pf_now_r > ps_now_r)) begin
        sig_nxt = macr_pkg::SIG_BUY;
      end else if (!(pf_bef_r < ps_bef_r) && (pf_now_r < ps_now_r)) begin
        sig_nxt = macr_pkg::SIG_SELL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s3_v_r) begin
      out_sig_r <= sig_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cross_signal = out_sig_r;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= macr_pkg::ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state: sweep after each configuration write
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      macr_pkg::ST_RUN: begin
        if (cfg_acc) state_nxt = macr_pkg::ST_SWEEP;
      end
      macr_pkg::ST_SWEEP: begin
        if (!swp_issue && !swp_dv_r) state_nxt = macr_pkg::ST_RUN;
      end
      default: state_nxt = macr_pkg::ST_RUN;
    endcase
  end

  // sweep counters, newest sample first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swp_dv_r <= 1'b0;
    end else begin
      swp_dv_r <= swp_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_acc) begin
      swp_age_r  <= '0;
      swp_slot_r <= wp_r;
    end else if (swp_issue) begin
      swp_age_r  <= swp_age_r + 1'b1;
      swp_slot_r <= (swp_slot_r == '0) ? AW'(DEPTH - 1) : swp_slot_r - 1'b1;
    end
    swp_age_d_r <= swp_age_r;
  end

  // checks
  `MACR_ASSERT_SAME(a_sweep_empty, state_r == macr_pkg::ST_SWEEP, !s1_v_r && !s2_v_r && !s3_v_r, "sweep with requests in flight")
  `MACR_ASSERT_SAME(a_cnt_sat, 1'b1, cnt_r <= CNT_W'(DEPTH), "sample count beyond saturation")
  `MACR_ASSERT_NEXT(a_cfg_sweep, cfg_acc, state_r == macr_pkg::ST_SWEEP, "no sweep after window write")
  `MACR_ASSERT_NEXT(a_stage_out, adv && s3_v_r, out_valid_r, "result lost between stage 3 and output")
  `MACR_ASSERT_SAME(a_sig_code, out_valid_r, out_sig_r == macr_pkg::SIG_NONE || out_sig_r == macr_pkg::SIG_BUY || out_sig_r == macr_pkg::SIG_SELL, "bad signal code")

endmodule

### tb/sv/tb_moving_average_crossover_detector_core.sv
module tb_moving_average_crossover_detector_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HIST_DEPTH   = 257;
  localparam int STUCK_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 900;
  localparam int QUIET_FROM   = 6000;
  localparam int QUIET_TO     = 9000;
  localparam int RANDOM_ITEMS = 1300;
  localparam int PLAN_ROWS    = 29;

  // short names for the codes used in the plan
  localparam macr_pkg::reg_idx_t FAST_IDX = macr_pkg::REG_FAST_WINDOW;
  localparam macr_pkg::reg_idx_t SLOW_IDX = macr_pkg::REG_SLOW_WINDOW;
  localparam macr_pkg::sig_t     NO_SIG   = macr_pkg::SIG_NONE;

  typedef enum logic [0:0] {
    ROW_ITEM,
    ROW_CFG
  } row_kind_t;

  typedef struct {
    row_kind_t                      kind;
    macr_pkg::reg_idx_t             idx;
    logic [macr_pkg::WIN_REG_W-1:0] win;
    logic [31:0]                    price;
    logic                           start;
    int                             reps;
    bit                             typed;
    macr_pkg::sig_t                 sig;
  } plan_row_t;

  // directed plan: typed results only for warm-up rows and one constant-price run
  plan_row_t plan [PLAN_ROWS] = '{
    '{ROW_ITEM, FAST_IDX, 9'd0,   32'hFFFF_FFFF, 1'b1, 257, 1'b1, NO_SIG},
    '{ROW_ITEM, FAST_IDX, 9'd0,   32'h0000_0000, 1'b0, 1,   1'b0, NO_SIG},
    '{ROW_CFG,  FAST_IDX, 9'd0,   32'h0,         1'b0, 0,   1'b0, NO_SIG},
    '{ROW_CFG,  SLOW_IDX, 9'd2,   32'h0,         1'b0, 0,   1'b0, NO_SIG},
    '{ROW_ITEM, FAST_IDX, 9'd0,   32'd100,       1'b1, 1,   1'b1, NO_SIG},
    '{ROW_ITEM, FAST_IDX, 9'd0,   32'd200,       1'b0, 1,   1'b1, NO_SIG},
    '{ROW_ITEM, FAST_IDX, 9'd0,   32'd300,       1'b0, 1,   1'b0, NO_SIG},
    '{ROW_ITEM, FAST_IDX, 9'd0,   32'd0,         1'b0, 1,   1'b0, NO_SIG},
    '{ROW_ITEM, FAST_IDX, 9'd0,   32'd1000,      1'b0, 1,   1'b0, NO_SIG},
    '{ROW_ITEM, FAST_IDX, 9'd0,   32'd1000,      1'b0, 1,   1'b0, NO_SIG},
    '{ROW_ITEM, FAST_IDX, 9'd0,   32'hFFFF_FFFF, 1'b0, 1,   1'b0, NO_SIG},
    '{ROW_ITEM, FAST_IDX, 9'd0,   32'd0,         1'b0, 1,   1'b0, NO_SIG},
    '{ROW_ITEM, FAST_IDX, 9'd0,   32'hFFFF_FFFF, 1'b0, 1,   1'b0, NO_SIG},
    '{ROW_CFG,  SLOW_IDX, 9'd3,   32'h0,         1'b0, 0,   1'b0, NO_SIG},
    '{ROW_ITEM, FAST_IDX, 9'd0,   32'd5,         1'b0, 1,   1'b0, NO_SIG},
    '{ROW_ITEM, FAST_IDX, 9'd0,   32'd7,         1'b0, 1,   1'b0, NO_SIG},
    '{ROW_CFG,  FAST_IDX, 9'd5,   32'h0,         1'b0, 0,   1'b0, NO_SIG},
    '{ROW_CFG,  SLOW_IDX, 9'd1,   32'h0,         1'b0, 0,   1'b0, NO_SIG},
    '{ROW_ITEM, FAST_IDX, 9'd0,   32'd50,        1'b1, 5,   1'b1, NO_SIG},
    '{ROW_ITEM, FAST_IDX, 9'd0,   32'd10,        1'b0, 1,   1'b0, NO_SIG},
    '{ROW_ITEM, FAST_IDX, 9'd0,   32'd90,        1'b0, 1,   1'b0, NO_SIG},
    '{ROW_CFG,  FAST_IDX, 9'd511, 32'h0,         1'b0, 0,   1'b0, NO_SIG},
    '{ROW_CFG,  SLOW_IDX, 9'd256, 32'h0,         1'b0, 0,   1'b0, NO_SIG},
    '{ROW_ITEM, FAST_IDX, 9'd0,   32'h8000_0000, 1'b1, 256, 1'b1, NO_SIG},
    '{ROW_ITEM, FAST_IDX, 9'd0,   32'h0000_0000, 1'b0, 1,   1'b0, NO_SIG},
    '{ROW_ITEM, FAST_IDX, 9'd0,   32'h7FFF_FFFF, 1'b0, 1,   1'b0, NO_SIG},
    '{ROW_ITEM, FAST_IDX, 9'd0,   32'h1234_5678, 1'b1, 1,   1'b1, NO_SIG},
    '{ROW_CFG,  FAST_IDX, 9'd256, 32'h0,         1'b0, 0,   1'b0, NO_SIG},
    '{ROW_CFG,  SLOW_IDX, 9'd300, 32'h0,         1'b0, 0,   1'b0, NO_SIG}
  };

  logic                           clk             = 1'b0;
  logic                           rst_n           = 1'b0;
  logic                           in_valid        = 1'b0;
  logic                           in_stall;
  logic [31:0]                    in_close_price  = '0;
  logic                           in_series_start = 1'b0;
  logic                           out_valid;
  logic                           out_stall       = 1'b0;
  macr_pkg::sig_t                 out_cross_signal;
  logic                           cfg_valid       = 1'b0;
  logic                           cfg_ready;
  macr_pkg::reg_idx_t             cfg_index       = FAST_IDX;
  logic [macr_pkg::WIN_REG_W-1:0] cfg_data        = '0;

  // predictor state
  logic [31:0]                    price_line [HIST_DEPTH];
  int unsigned                    head_slot  = 0;
  int unsigned                    series_len = 0;
  logic [macr_pkg::WIN_REG_W-1:0] fast_reg   = macr_pkg::FAST_RESET;
  logic [macr_pkg::WIN_REG_W-1:0] slow_reg   = macr_pkg::SLOW_RESET;
  logic [31:0]                    walk_price = 32'd1_000_000;

  macr_pkg::sig_t expected_signals [$];
  macr_pkg::sig_t wanted;
  int   mismatch_count = 0;
  int   results_seen   = 0;
  int   hold_left      = 0;
  bit   pressure_done  = 1'b0;
  int   cycle_no       = 0;
  int   stuck_cycles   = 0;

  moving_average_crossover_detector_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_close_price   (in_close_price),
    .in_series_start  (in_series_start),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_cross_signal (out_cross_signal),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  // window register clamped to 1..256
  function automatic int unsigned clamp_window(logic [macr_pkg::WIN_REG_W-1:0] w);
    if (w == 0) return 1;
    if (w > 256) return 256;
    return 32'(w);
  endfunction

  // sum of w prices starting at a given age, newest is age 0
  function automatic logic [40:0] span_total(int unsigned age0, int unsigned w);
    logic [40:0] acc;
    int unsigned slot;
    acc = '0;
    for (int unsigned i = 0; i < w; i++) begin
      slot = (head_slot + HIST_DEPTH - ((age0 + i) % HIST_DEPTH)) % HIST_DEPTH;
      acc += 41'(price_line[slot]);
    end
    return acc;
  endfunction

  // sign of fast average minus slow average, by cross-multiplying
  function automatic int avg_order(logic [40:0] fs, logic [40:0] ss,
                                   int unsigned fw, int unsigned sw);
    logic [63:0] lhs;
    logic [63:0] rhs;
    lhs = 64'(fs) * 64'(sw);
    rhs = 64'(ss) * 64'(fw);
    if (lhs > rhs) return 1;
    if (lhs < rhs) return -1;
    return 0;
  endfunction

  // take one price into the predictor, return the cross it causes
  function automatic macr_pkg::sig_t advance_crossover(logic [31:0] price, logic start);
    int unsigned    fw;
    int unsigned    sw;
    int unsigned    widest;
    int             now_ord;
    int             prev_ord;
    macr_pkg::sig_t sig;
    fw = clamp_window(fast_reg);
    sw = clamp_window(slow_reg);
    widest = (fw > sw) ? fw : sw;
    sig = macr_pkg::SIG_NONE;
    if (start) series_len = 0;
    head_slot = (head_slot + 1) % HIST_DEPTH;
    price_line[head_slot] = price;
    if (series_len < HIST_DEPTH) series_len++;
    if (series_len > widest) begin
      now_ord  = avg_order(span_total(0, fw), span_total(0, sw), fw, sw);
      prev_ord = avg_order(span_total(1, fw), span_total(1, sw), fw, sw);
      if (prev_ord <= 0 && now_ord > 0) sig = macr_pkg::SIG_BUY;
      else if (prev_ord >= 0 && now_ord < 0) sig = macr_pkg::SIG_SELL;
    end
    return sig;
  endfunction

  // random walk with the odd jump to the extremes
  function automatic logic [31:0] next_price();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 5) walk_price = $urandom;
    else if (roll < 8) walk_price = '1;
    else if (roll < 11) walk_price = '0;
    else walk_price = walk_price + $urandom_range(4000) - 32'd2000;
    return walk_price;
  endfunction

  // mostly short windows so that warm-up stays brief
  function automatic logic [macr_pkg::WIN_REG_W-1:0] pick_window();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) return 9'($urandom_range(12, 1));
    if (roll < 70) return 9'($urandom_range(40, 13));
    if (roll < 78) return '0;
    if (roll < 86) return 9'($urandom_range(511, 256));
    if (roll < 92) return 9'd1;
    return 9'($urandom_range(255, 41));
  endfunction

  task automatic report_mismatch(string what, macr_pkg::sig_t got, macr_pkg::sig_t want);
    $display("mismatch at result %0d: %s, got %0d want %0d", results_seen, what, got, want);
    mismatch_count++;
  endtask

  // offer one price request, wait for it to be taken, note its result
  task automatic offer_sample(logic [31:0] price, logic start, bit typed,
                              macr_pkg::sig_t typed_sig);
    macr_pkg::sig_t predicted;
    cfg_valid <= 1'b0;
    while ((cycle_no < QUIET_FROM || cycle_no >= QUIET_TO) && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_close_price  <= price;
    in_series_start <= start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = advance_crossover(price, start);
    expected_signals = {expected_signals, (typed ? typed_sig : predicted)};
  endtask

  // window write once every result is out
  task automatic write_window(macr_pkg::reg_idx_t idx, logic [macr_pkg::WIN_REG_W-1:0] val);
    in_valid <= 1'b0;
    while (expected_signals.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == macr_pkg::REG_FAST_WINDOW) fast_reg = val;
    else slow_reg = val;
  endtask

  // result checking and receiver stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_signals.size() == 0) begin
          report_mismatch("result with nothing expected", out_cross_signal,
                          macr_pkg::SIG_NONE);
        end else begin
          wanted = expected_signals.pop_front();
          if (out_cross_signal !== wanted)
            report_mismatch("cross_signal", out_cross_signal, wanted);
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!pressure_done && results_seen >= HOLD_AFTER && in_valid) begin
        // long hold-off so the pipeline fills and the input backs up
        pressure_done = 1'b1;
        hold_left     = HOLD_CYCLES;
        out_stall    <= 1'b1;
      end else begin
        out_stall <= (cycle_no < QUIET_FROM || cycle_no >= QUIET_TO) &&
                     ($urandom_range(99) < 7);
      end
    end
  end

  // watchdog on cycles with no request taken anywhere
  always @(posedge clk) begin
    cycle_no++;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int random_items;
    int phase_len;
    bit fresh;
    random_items = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed plan
    foreach (plan[r]) begin
      if (plan[r].kind == ROW_CFG) begin
        write_window(plan[r].idx, plan[r].win);
      end else begin
        for (int n = 0; n < plan[r].reps; n++)
          offer_sample(plan[r].price, plan[r].start && n == 0, plan[r].typed, plan[r].sig);
      end
    end

    // random phases, each with fresh windows
    while (random_items < RANDOM_ITEMS) begin
      write_window(macr_pkg::REG_FAST_WINDOW, pick_window());
      write_window(macr_pkg::REG_SLOW_WINDOW, pick_window());
      phase_len = $urandom_range(200, 50);
      fresh = ($urandom_range(99) < 80);
      for (int k = 0; k < phase_len; k++)
        offer_sample(next_price(), (k == 0 && fresh) || $urandom_range(63) == 0,
                     1'b0, macr_pkg::SIG_NONE);
      random_items += phase_len;
    end

    // drain
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    while (expected_signals.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_signals.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### moving_average_crossover_detector_core.f
+incdir+rtl
rtl/macr_pkg.sv
rtl/macr_ram.sv
rtl/moving_average_crossover_detector_core.sv
tb/sv/tb_moving_average_crossover_detector_core.sv
